// ===== sv/mig_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix inverse package
// Shared constants and the sequencer state type of the Gauss-Jordan inverter.
// ----------------------------------------------------------------------------
package mig_pkg;

    localparam int MATRIX_SIZE_DEF   = 4;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int DATA_W            = 32;
    localparam int THR_W             = 17;
    localparam logic [THR_W-1:0] THR_RESET = 17'd33;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_INIT,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_SW_RD1,
        ST_SW_RD2,
        ST_SW_WR1,
        ST_SW_WR2,
        ST_DV_RD,
        ST_DV_W,
        ST_DV_WW,
        ST_DV_RW,
        ST_EL_F,
        ST_EL_FL,
        ST_EL_RD1,
        ST_EL_RD2,
        ST_EL_MUL,
        ST_EL_WR,
        ST_OUT_RD,
        ST_OUT_SEND
    } mig_state_t;

endpackage

// ===== sv/matrix_inverse_gauss_jordan_top.sv =====
// ----------------------------------------------------------------------------
// Gauss-Jordan matrix inverter
// A matrix of MATRIX_SIZE squared signed fixed-point words is loaded one word per
// transfer in row-major order; after the last word the block inverts it and
// returns the inverse in the same order with a status bit (1 when no usable
// pivot was found) and last on the final word. Both matrices live in two
// simple dual-port synchronous memories worked by a read-modify-write sequencer.
// The pivot columns are scaled by a bit-serial divider; the sequencer also
// sets up the identity, probes for pivots, swaps columns and eliminates. Each
// result word is read in ST_OUT_RD and offered in ST_OUT_SEND. The input
// accepts no word from the last load transfer until the last result transfer.
// ----------------------------------------------------------------------------
module matrix_inverse_gauss_jordan_top #(
    parameter int MATRIX_SIZE   = mig_pkg::MATRIX_SIZE_DEF,
    parameter int FRACTION_BITS = mig_pkg::FRACTION_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [mig_pkg::THR_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [mig_pkg::DATA_W-1:0]  s_element_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mig_pkg::DATA_W-1:0]  m_result_value,
    output logic                        m_status,
    output logic                        m_last
);

    localparam int DW    = mig_pkg::DATA_W;
    localparam int CELLS = MATRIX_SIZE * MATRIX_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(MATRIX_SIZE) + 1;
    localparam int PW    = 2 * DW;
    localparam logic [CW-1:0] LAST_IDX = CW'(MATRIX_SIZE - 1);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] row,
                                                input logic [CW-1:0] col);
        cell_addr = AW'(int'(row) * MATRIX_SIZE + int'(col));
    endfunction

    function automatic logic [DW-1:0] sub_sat(input logic [DW-1:0] a, input logic [PW-1:0] p);
        logic [PW:0] diff;
        diff = {{(PW-DW+1){a[DW-1]}}, a} - {p[PW-1], ($signed(p) >>> FRACTION_BITS)};
        if (!diff[PW] && (|diff[PW-1:DW-1])) begin
            sub_sat = {1'b0, {(DW-1){1'b1}}};
        end else if (diff[PW] && !(&diff[PW-1:DW-1])) begin
            sub_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            sub_sat = diff[DW-1:0];
        end
    endfunction

    mig_pkg::mig_state_t state_reg, state_next;

    logic [DW-1:0] w_mem [CELLS];
    logic [DW-1:0] r_mem [CELLS];
    logic [DW-1:0] w_rdata_reg, r_rdata_reg;
    logic [AW-1:0] w_raddr, r_raddr, w_waddr, r_waddr;
    logic          w_we, r_we;
    logic [DW-1:0] w_wdata, r_wdata;

    logic [mig_pkg::THR_W-1:0] thr_reg;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] c_reg, c_next, r_reg, r_next, i_reg, i_next;
    logic [DW-1:0] piv_reg, piv_next;
    logic [DW-1:0] f_reg, f_next;
    logic [DW-1:0] pw_reg, pw_next, pr_reg, pr_next;
    logic [DW-1:0] qw_reg, qw_next, qr_reg, qr_next;
    logic [PW-1:0] prodw_reg, prodw_next, prodr_reg, prodr_next;
    logic          status_reg, status_next;

    logic          div_start, div_done;
    logic [DW-1:0] div_a, div_q;
    logic [DW-1:0] mag;
    logic          pivot_ok;

    mig_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (piv_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (w_we) begin
            w_mem[w_waddr] <= w_wdata;
        end
        if (r_we) begin
            r_mem[r_waddr] <= r_wdata;
        end
        w_rdata_reg <= w_mem[w_raddr];
        r_rdata_reg <= r_mem[r_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= mig_pkg::THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        mag      = w_rdata_reg[DW-1] ? (~w_rdata_reg + 1'b1) : w_rdata_reg;
        pivot_ok = (w_rdata_reg != '0) && (mag >= DW'(thr_reg));
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        c_next      = c_reg;
        r_next      = r_reg;
        i_next      = i_reg;
        piv_next    = piv_reg;
        f_next      = f_reg;
        pw_next     = pw_reg;
        pr_next     = pr_reg;
        qw_next     = qw_reg;
        qr_next     = qr_reg;
        prodw_next  = prodw_reg;
        prodr_next  = prodr_reg;
        status_next = status_reg;
        w_raddr = cell_addr(i_reg, c_reg);
        r_raddr = cell_addr(i_reg, c_reg);
        w_we    = 1'b0;
        r_we    = 1'b0;
        w_waddr = cell_addr(i_reg, c_reg);
        r_waddr = cell_addr(i_reg, c_reg);
        w_wdata = s_element_value;
        r_wdata = div_q;
        div_start = 1'b0;
        div_a     = w_rdata_reg;
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        unique case (state_reg)
            mig_pkg::ST_LOAD: begin
                s_ready = 1'b1;
                w_waddr = cnt_reg;
                if (s_valid) begin
                    w_we = 1'b1;
                    if (cnt_reg == LAST_CELL) begin
                        cnt_next   = '0;
                        i_next     = '0;
                        r_next     = '0;
                        state_next = mig_pkg::ST_INIT;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            mig_pkg::ST_INIT: begin
                r_we    = 1'b1;
                r_waddr = cell_addr(i_reg, r_reg);
                r_wdata = (i_reg == r_reg) ? DW'(1) << FRACTION_BITS : '0;
                if (r_reg == LAST_IDX) begin
                    r_next = '0;
                    if (i_reg == LAST_IDX) begin
                        c_next     = '0;
                        state_next = mig_pkg::ST_SRCH_RD;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end else begin
                    r_next = r_reg + 1'b1;
                end
            end
            mig_pkg::ST_SRCH_RD: begin
                w_raddr    = cell_addr(c_reg, r_reg);
                state_next = mig_pkg::ST_SRCH_CHK;
            end
            mig_pkg::ST_SRCH_CHK: begin
                if (pivot_ok) begin
                    piv_next   = w_rdata_reg;
                    i_next     = '0;
                    state_next = (r_reg != c_reg) ? mig_pkg::ST_SW_RD1 : mig_pkg::ST_DV_RD;
                end else if (r_reg == LAST_IDX) begin
                    status_next = 1'b1;
                    cnt_next    = '0;
                    state_next  = mig_pkg::ST_OUT_RD;
                end else begin
                    r_next     = r_reg + 1'b1;
                    state_next = mig_pkg::ST_SRCH_RD;
                end
            end
            mig_pkg::ST_SW_RD1: begin
                w_raddr    = cell_addr(i_reg, r_reg);
                r_raddr    = cell_addr(i_reg, r_reg);
                state_next = mig_pkg::ST_SW_RD2;
            end
            mig_pkg::ST_SW_RD2: begin
                qw_next    = w_rdata_reg;
                qr_next    = r_rdata_reg;
                state_next = mig_pkg::ST_SW_WR1;
            end
            mig_pkg::ST_SW_WR1: begin
                w_we       = 1'b1;
                r_we       = 1'b1;
                w_waddr    = cell_addr(i_reg, r_reg);
                r_waddr    = cell_addr(i_reg, r_reg);
                w_wdata    = w_rdata_reg;
                r_wdata    = r_rdata_reg;
                state_next = mig_pkg::ST_SW_WR2;
            end
            mig_pkg::ST_SW_WR2: begin
                w_we    = 1'b1;
                r_we    = 1'b1;
                w_wdata = qw_reg;
                r_wdata = qr_reg;
                if (i_reg == LAST_IDX) begin
                    i_next     = '0;
                    state_next = mig_pkg::ST_DV_RD;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = mig_pkg::ST_SW_RD1;
                end
            end
            mig_pkg::ST_DV_RD: begin
                state_next = mig_pkg::ST_DV_W;
            end
            mig_pkg::ST_DV_W: begin
                div_start  = 1'b1;
                pr_next    = r_rdata_reg;
                state_next = mig_pkg::ST_DV_WW;
            end
            mig_pkg::ST_DV_WW: begin
                div_a = pr_reg;
                if (div_done) begin
                    w_we       = 1'b1;
                    w_wdata    = div_q;
                    div_start  = 1'b1;
                    state_next = mig_pkg::ST_DV_RW;
                end
            end
            mig_pkg::ST_DV_RW: begin
                if (div_done) begin
                    r_we = 1'b1;
                    if (i_reg == LAST_IDX) begin
                        i_next     = '0;
                        r_next     = '0;
                        state_next = mig_pkg::ST_EL_F;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = mig_pkg::ST_DV_RD;
                    end
                end
            end
            mig_pkg::ST_EL_F: begin
                w_raddr = cell_addr(c_reg, r_reg);
                if (r_reg == c_reg) begin
                    if (r_reg == LAST_IDX) begin
                        if (c_reg == LAST_IDX) begin
                            status_next = 1'b0;
                            cnt_next    = '0;
                            state_next  = mig_pkg::ST_OUT_RD;
                        end else begin
                            c_next     = c_reg + 1'b1;
                            r_next     = c_reg + 1'b1;
                            state_next = mig_pkg::ST_SRCH_RD;
                        end
                    end else begin
                        r_next = r_reg + 1'b1;
                    end
                end else begin
                    state_next = mig_pkg::ST_EL_FL;
                end
            end
            mig_pkg::ST_EL_FL: begin
                f_next     = w_rdata_reg;
                i_next     = '0;
                state_next = mig_pkg::ST_EL_RD1;
            end
            mig_pkg::ST_EL_RD1: begin
                state_next = mig_pkg::ST_EL_RD2;
            end
            mig_pkg::ST_EL_RD2: begin
                pw_next    = w_rdata_reg;
                pr_next    = r_rdata_reg;
                w_raddr    = cell_addr(i_reg, r_reg);
                r_raddr    = cell_addr(i_reg, r_reg);
                state_next = mig_pkg::ST_EL_MUL;
            end
            mig_pkg::ST_EL_MUL: begin
                prodw_next = PW'($signed(pw_reg) * $signed(f_reg));
                prodr_next = PW'($signed(pr_reg) * $signed(f_reg));
                qw_next    = w_rdata_reg;
                qr_next    = r_rdata_reg;
                state_next = mig_pkg::ST_EL_WR;
            end
            mig_pkg::ST_EL_WR: begin
                w_we    = 1'b1;
                r_we    = 1'b1;
                w_waddr = cell_addr(i_reg, r_reg);
                r_waddr = cell_addr(i_reg, r_reg);
                w_wdata = sub_sat(qw_reg, prodw_reg);
                r_wdata = sub_sat(qr_reg, prodr_reg);
                if (i_reg == LAST_IDX) begin
                    i_next = '0;
                    if (r_reg == LAST_IDX) begin
                        if (c_reg == LAST_IDX) begin
                            status_next = 1'b0;
                            cnt_next    = '0;
                            state_next  = mig_pkg::ST_OUT_RD;
                        end else begin
                            c_next     = c_reg + 1'b1;
                            r_next     = c_reg + 1'b1;
                            state_next = mig_pkg::ST_SRCH_RD;
                        end
                    end else begin
                        r_next     = r_reg + 1'b1;
                        state_next = mig_pkg::ST_EL_F;
                    end
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = mig_pkg::ST_EL_RD1;
                end
            end
            mig_pkg::ST_OUT_RD: begin
                r_raddr    = cnt_reg;
                state_next = mig_pkg::ST_OUT_SEND;
            end
            mig_pkg::ST_OUT_SEND: begin
                r_raddr = cnt_reg;
                m_valid = 1'b1;
                if (m_ready) begin
                    if (cnt_reg == LAST_CELL) begin
                        cnt_next   = '0;
                        state_next = mig_pkg::ST_LOAD;
                    end else begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = mig_pkg::ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = mig_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= mig_pkg::ST_LOAD;
            cnt_reg    <= '0;
            c_reg      <= '0;
            r_reg      <= '0;
            i_reg      <= '0;
            status_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            c_reg      <= c_next;
            r_reg      <= r_next;
            i_reg      <= i_next;
            status_reg <= status_next;
        end
        piv_reg   <= piv_next;
        f_reg     <= f_next;
        pw_reg    <= pw_next;
        pr_reg    <= pr_next;
        qw_reg    <= qw_next;
        qr_reg    <= qr_next;
        prodw_reg <= prodw_next;
        prodr_reg <= prodr_next;
    end

    assign m_result_value = r_rdata_reg;
    assign m_status       = status_reg;
    assign m_last         = (cnt_reg == LAST_CELL);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result channels open at the same time");

    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && cnt_reg == LAST_CELL) |=> (state_reg == mig_pkg::ST_INIT))
        else $error("final load transfer did not start the inversion");

    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> s_ready)
        else $error("input not reopened after the last result transfer");

    a_div_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mig_pkg::ST_DV_RW && div_done) |-> r_we)
        else $error("scaled result word not written back");

endmodule

// ===== sv/mig_div.sv =====
// ----------------------------------------------------------------------------
// Fixed-point divider
// Restoring divider that returns (a << FRACTION_BITS) / p, truncated toward
// zero and saturated to 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mig_div #(
    parameter int FRACTION_BITS = mig_pkg::FRACTION_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [mig_pkg::DATA_W-1:0]  dividend,
    input  logic [mig_pkg::DATA_W-1:0]  divisor,
    output logic                        done,
    output logic [mig_pkg::DATA_W-1:0]  quotient
);

    localparam int DW = mig_pkg::DATA_W;
    localparam int QW = DW + FRACTION_BITS;
    localparam int CW = $clog2(QW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [DW-1:0] mp_reg, mp_next;
    logic [QW-1:0] dvd_reg, dvd_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW:0]   trial;
    logic [DW-1:0] ma;
    logic [DW-1:0] mp;

    always_comb begin
        ma    = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
        mp    = divisor[DW-1] ? (~divisor + 1'b1) : divisor;
        trial = {rem_reg[DW-1:0], dvd_reg[QW-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        mp_next   = mp_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[DW-1] ^ divisor[DW-1];
            mp_next   = mp;
            dvd_next  = {ma, {FRACTION_BITS{1'b0}}};
            quo_next  = '0;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[QW-2:0], 1'b0};
            if (trial >= {1'b0, mp_reg}) begin
                rem_next = trial - {1'b0, mp_reg};
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg <= neg_next;
        mp_reg  <= mp_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    always_comb begin
        if (!neg_reg) begin
            if (|quo_reg[QW-1:DW-1]) begin
                quotient = {1'b0, {(DW-1){1'b1}}};
            end else begin
                quotient = quo_reg[DW-1:0];
            end
        end else begin
            if ((|quo_reg[QW-1:DW]) || (quo_reg[DW-1] && (|quo_reg[DW-2:0]))) begin
                quotient = {1'b1, {(DW-1){1'b0}}};
            end else begin
                quotient = ~quo_reg[DW-1:0] + 1'b1;
            end
        end
    end

    assign done = done_reg;

endmodule
